@@ hw/rtl/vn2_pkg.sv @@
// ----------------------------------------------------------------------------
// vn2_pkg
// Shared constants and types for the 2D value noise unit: field widths,
// lattice hash constants and the corner hash record.
// ----------------------------------------------------------------------------
package vn2_pkg;

    localparam int COORD_W     = 24;
    localparam int NOISE_W     = 18;
    localparam int HASH_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [HASH_W-1:0] HASH_Y_MUL = 32'd57;
    localparam int                HASH_SHIFT = 13;
    localparam logic [HASH_W-1:0] HASH_MUL   = 32'd15731;
    localparam logic [HASH_W-1:0] HASH_ADD   = 32'd789221;
    localparam logic [HASH_W-1:0] HASH_OFF   = 32'd1376312589;

    // Scrambled lattice index of each cell corner, ready for the hash.
    typedef struct packed {
        logic [HASH_W-1:0] n00;
        logic [HASH_W-1:0] n10;
        logic [HASH_W-1:0] n01;
        logic [HASH_W-1:0] n11;
    } corner_n_t;

    // Queue status: not_empty is seen by the back end, full drives the input stall.
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_status_t;

endpackage

@@ hw/rtl/vn2_front.sv @@
// ----------------------------------------------------------------------------
// vn2_front
// Splits a point into lattice cell and fraction (floor semantics) and forms
// the scrambled index of the four cell corners.
// ----------------------------------------------------------------------------
module vn2_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic signed [vn2_pkg::COORD_W-1:0] x_coord,
    input  logic signed [vn2_pkg::COORD_W-1:0] y_coord,
    output vn2_pkg::corner_n_t                 corner_n,
    output logic        [FRAC_BITS-1:0]        x_frac,
    output logic        [FRAC_BITS-1:0]        y_frac
);

    logic signed [vn2_pkg::HASH_W-1:0] x_ext;
    logic signed [vn2_pkg::HASH_W-1:0] y_ext;
    logic        [vn2_pkg::HASH_W-1:0] x_cell;
    logic        [vn2_pkg::HASH_W-1:0] y_cell;
    logic        [vn2_pkg::HASH_W-1:0] n_base;
    logic        [vn2_pkg::HASH_W-1:0] n10;
    logic        [vn2_pkg::HASH_W-1:0] n01;
    logic        [vn2_pkg::HASH_W-1:0] n11;

    function automatic logic [vn2_pkg::HASH_W-1:0] scramble(
        input logic [vn2_pkg::HASH_W-1:0] n
    );
        return n ^ (n << vn2_pkg::HASH_SHIFT);
    endfunction

    always_comb
    begin
        x_ext  = vn2_pkg::HASH_W'(x_coord);
        y_ext  = vn2_pkg::HASH_W'(y_coord);
        // arithmetic shift floors toward minus infinity
        x_cell = x_ext >>> FRAC_BITS;
        y_cell = y_ext >>> FRAC_BITS;
        n_base = x_cell + vn2_pkg::HASH_Y_MUL * y_cell;
        n10    = n_base + vn2_pkg::HASH_W'(1);
        n01    = n_base + vn2_pkg::HASH_Y_MUL;
        n11    = n01 + vn2_pkg::HASH_W'(1);

        corner_n.n00 = scramble(n_base);
        corner_n.n10 = scramble(n10);
        corner_n.n01 = scramble(n01);
        corner_n.n11 = scramble(n11);

        x_frac = x_coord[FRAC_BITS-1:0];
        y_frac = y_coord[FRAC_BITS-1:0];
    end

endmodule

@@ hw/rtl/vn2_queue.sv @@
// ----------------------------------------------------------------------------
// vn2_queue
// Short FIFO between the front end and the hash/blend pipeline.
// ----------------------------------------------------------------------------
module vn2_queue #(
    parameter int DATA_W = 144
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_W-1:0]     push_data,
    input  logic                  pop,
    output logic [DATA_W-1:0]     head_data,
    output vn2_pkg::queue_status_t status
);

    logic [DATA_W-1:0]          entry_reg [vn2_pkg::QUEUE_DEPTH];
    logic [vn2_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [vn2_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [vn2_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [vn2_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [vn2_pkg::QPTR_W:0]   count_reg;
    logic [vn2_pkg::QPTR_W:0]   count_next;
    logic                       do_push;
    logic                       do_pop;

    always_comb
    begin
        status.full      = (count_reg == (vn2_pkg::QPTR_W+1)'(vn2_pkg::QUEUE_DEPTH));
        status.not_empty = (count_reg != '0);
        do_push          = push && !status.full;
        do_pop           = pop && status.not_empty;
        wr_ptr_next      = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next      = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next       = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
        head_data = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/vn2_hash_lane.sv @@
// ----------------------------------------------------------------------------
// vn2_hash_lane
// Four-stage lattice hash of one corner, ending in the corner value
// 1 - h/2^30 with OUT_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module vn2_hash_lane #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              advance,
    input  logic [vn2_pkg::HASH_W-1:0]        n,
    output logic signed [OUT_FRAC_BITS+1:0]   corner_value
);

    localparam int VAL_W = OUT_FRAC_BITS + 2;
    localparam logic [VAL_W-1:0] ONE_V = VAL_W'(1) << OUT_FRAC_BITS;

    logic [vn2_pkg::HASH_W-1:0] n1_reg;
    logic [vn2_pkg::HASH_W-1:0] sq_reg;
    logic [vn2_pkg::HASH_W-1:0] n2_reg;
    logic [vn2_pkg::HASH_W-1:0] poly_reg;
    logic [vn2_pkg::HASH_W-1:0] prod_reg;
    logic [vn2_pkg::HASH_W-1:0] hash_sum;
    logic [VAL_W-1:0]           value_next;
    logic [VAL_W-1:0]           value_reg;

    always_comb
    begin
        hash_sum   = prod_reg + vn2_pkg::HASH_OFF;
        // keep 31 bits, then drop the low bits below the output resolution
        value_next = ONE_V - {1'b0, hash_sum[30:30-OUT_FRAC_BITS]};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n1_reg    <= n;
            sq_reg    <= n * n;
            n2_reg    <= n1_reg;
            poly_reg  <= sq_reg * vn2_pkg::HASH_MUL + vn2_pkg::HASH_ADD;
            prod_reg  <= n2_reg * poly_reg;
            value_reg <= value_next;
        end
    end

    assign corner_value = $signed(value_reg);

endmodule

@@ hw/rtl/vn2_back.sv @@
// ----------------------------------------------------------------------------
// vn2_back
// Hash pipeline for the four corners followed by the two blend stages, the
// second of which is the output register. All stages advance together unless the output stalls.
// ----------------------------------------------------------------------------
module vn2_back #(
    parameter int FRAC_BITS     = 8,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  vn2_pkg::corner_n_t                 head_n,
    input  logic        [FRAC_BITS-1:0]        head_x_frac,
    input  logic        [FRAC_BITS-1:0]        head_y_frac,
    output logic                               pop,
    output logic                               noise_valid,
    input  logic                               noise_stall,
    output logic signed [vn2_pkg::NOISE_W-1:0] noise_value
);

    localparam int VAL_W  = OUT_FRAC_BITS + 2;
    localparam int W_W    = FRAC_BITS + 2;
    localparam int PROD_W = VAL_W + W_W;
    localparam int HASH_STAGES = 4;
    localparam logic signed [W_W-1:0] ONE_W = W_W'(1) << FRAC_BITS;

    logic                        advance;
    logic [HASH_STAGES:0]        valid_reg;
    logic [HASH_STAGES:0]        valid_next;
    logic                        out_valid_reg;
    logic [FRAC_BITS-1:0]        x_frac_reg [HASH_STAGES];
    logic [FRAC_BITS-1:0]        y_frac_reg [HASH_STAGES+1];
    logic signed [VAL_W-1:0]     v00;
    logic signed [VAL_W-1:0]     v10;
    logic signed [VAL_W-1:0]     v01;
    logic signed [VAL_W-1:0]     v11;
    logic signed [VAL_W-1:0]     row0_reg;
    logic signed [VAL_W-1:0]     row1_reg;
    logic signed [VAL_W-1:0]     mix;
    logic signed [VAL_W+vn2_pkg::NOISE_W-1:0] mix_ext;
    logic signed [vn2_pkg::NOISE_W-1:0] noise_reg;

    // Weighted sum of two values, each product floored before the add.
    function automatic logic signed [VAL_W-1:0] blend(
        input logic signed [VAL_W-1:0] p,
        input logic signed [VAL_W-1:0] q,
        input logic [FRAC_BITS-1:0]    f
    );
        logic signed [W_W-1:0]    wq;
        logic signed [W_W-1:0]    wp;
        logic signed [PROD_W-1:0] pp;
        logic signed [PROD_W-1:0] pq;
        logic signed [PROD_W-1:0] s;
        wq = $signed({2'b00, f});
        wp = ONE_W - wq;
        pp = p * wp;
        pq = q * wq;
        s  = (pp >>> FRAC_BITS) + (pq >>> FRAC_BITS);
        return s[VAL_W-1:0];
    endfunction

    assign advance = !out_valid_reg || !noise_stall;
    assign pop     = advance && head_valid;

    vn2_hash_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_lane00 (
        .clk(clk), .advance(advance), .n(head_n.n00), .corner_value(v00)
    );
    vn2_hash_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_lane10 (
        .clk(clk), .advance(advance), .n(head_n.n10), .corner_value(v10)
    );
    vn2_hash_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_lane01 (
        .clk(clk), .advance(advance), .n(head_n.n01), .corner_value(v01)
    );
    vn2_hash_lane #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_lane11 (
        .clk(clk), .advance(advance), .n(head_n.n11), .corner_value(v11)
    );

    always_comb
    begin
        valid_next = {valid_reg[HASH_STAGES-1:0], head_valid};
        mix        = blend(row0_reg, row1_reg, y_frac_reg[HASH_STAGES]);
        mix_ext    = (VAL_W+vn2_pkg::NOISE_W)'(mix);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= valid_reg[HASH_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_frac_reg[0] <= head_x_frac;
            y_frac_reg[0] <= head_y_frac;
            for (int i = 1; i < HASH_STAGES; i++)
            begin
                x_frac_reg[i] <= x_frac_reg[i-1];
            end
            for (int i = 1; i <= HASH_STAGES; i++)
            begin
                y_frac_reg[i] <= y_frac_reg[i-1];
            end
            row0_reg  <= blend(v00, v10, x_frac_reg[HASH_STAGES-1]);
            row1_reg  <= blend(v01, v11, x_frac_reg[HASH_STAGES-1]);
            noise_reg <= mix_ext[vn2_pkg::NOISE_W-1:0];
        end
    end

    assign noise_valid = out_valid_reg;
    assign noise_value = noise_reg;

endmodule

@@ hw/rtl/value_noise_2d_unit.sv @@
// An accepted item passes through the queue, the hash lanes, the row blend and the output register.
// Throughput: one item per cycle while the output does not stall, set by the fully pipelined hash lanes
// (three 32-bit multiply stages) and the two blend stages.
// The 4-entry queue absorbs short output stalls; input stalls only when full.
// Reset clears the queue and all valid flags; no queued or in-flight item survives reset.
// ----------------------------------------------------------------------------
// value_noise_2d_unit
// 2D value noise on an integer lattice: floors the point to its cell,
// hashes the four corners and blends them bilinearly in fixed point.
// ----------------------------------------------------------------------------
module value_noise_2d_unit #(
    parameter int FRAC_BITS     = 8,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               coord_valid,
    output logic                               coord_stall,
    input  logic signed [vn2_pkg::COORD_W-1:0] x_coord,
    input  logic signed [vn2_pkg::COORD_W-1:0] y_coord,
    output logic                               noise_valid,
    input  logic                               noise_stall,
    output logic signed [vn2_pkg::NOISE_W-1:0] noise_value
);

    localparam int ENTRY_W = $bits(vn2_pkg::corner_n_t) + 2 * FRAC_BITS;

    vn2_pkg::corner_n_t      front_n;
    logic [FRAC_BITS-1:0]    front_x_frac;
    logic [FRAC_BITS-1:0]    front_y_frac;
    logic [ENTRY_W-1:0]      head_data;
    vn2_pkg::corner_n_t      head_n;
    logic [FRAC_BITS-1:0]    head_x_frac;
    logic [FRAC_BITS-1:0]    head_y_frac;
    vn2_pkg::queue_status_t  q_status;
    logic                    pop;

    vn2_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .x_coord  (x_coord),
        .y_coord  (y_coord),
        .corner_n (front_n),
        .x_frac   (front_x_frac),
        .y_frac   (front_y_frac)
    );

    vn2_queue #(.DATA_W(ENTRY_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (coord_valid),
        .push_data ({front_n, front_x_frac, front_y_frac}),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    assign coord_stall = q_status.full;
    assign {head_n, head_x_frac, head_y_frac} = head_data;

    vn2_back #(
        .FRAC_BITS     (FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_status.not_empty),
        .head_n      (head_n),
        .head_x_frac (head_x_frac),
        .head_y_frac (head_y_frac),
        .pop         (pop),
        .noise_valid (noise_valid),
        .noise_stall (noise_stall),
        .noise_value (noise_value)
    );

endmodule

@@ dv/value_noise_2d_unit_tb.sv @@
// ----------------------------------------------------------------------------
// value_noise_2d_unit_tb
// Self-checking bench for the 2D value noise unit. A queue of points (corner
// cases first, then random points biased toward the lattice, the origin and
// the range ends) feeds a clocked driver. A clocked monitor compares each
// noise item with the value predicted at input acceptance. Sender and
// receiver pause at random in the first two of three phases.
// ----------------------------------------------------------------------------
module value_noise_2d_unit_tb;

    localparam int COORD_W       = vn2_pkg::COORD_W;
    localparam int NOISE_W       = vn2_pkg::NOISE_W;
    localparam int FRAC_BITS     = 8;
    localparam int OUT_FRAC_BITS = 16;
    localparam int RANDOM_POINTS = 1850;
    localparam int TAIL_CYCLES   = 12;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    logic                      clk;
    logic                      rst_n       = 1'b0;
    logic                      coord_valid = 1'b0;
    logic                      coord_stall;
    logic signed [COORD_W-1:0] x_coord     = '0;
    logic signed [COORD_W-1:0] y_coord     = '0;
    logic                      noise_valid;
    logic                      noise_stall = 1'b0;
    logic signed [NOISE_W-1:0] noise_value;

    point_t                    point_backlog[$];
    logic signed [NOISE_W-1:0] expected_noise[$];
    int                        points_total   = 1;
    int                        points_sent    = 0;
    int                        noise_seen     = 0;
    int                        mismatch_count = 0;

    value_noise_2d_unit #(
        .FRAC_BITS     (FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .coord_valid (coord_valid),
        .coord_stall (coord_stall),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .noise_valid (noise_valid),
        .noise_stall (noise_stall),
        .noise_value (noise_value)
    );

    // Hash one lattice corner and map it to 1 - h/2^30 in output fixed point.
    function automatic longint corner_level(logic [31:0] ci, logic [31:0] cj);
        logic [31:0] n;
        logic [31:0] h;
        n = ci + 32'd57 * cj;
        n = n ^ (n << 13);
        h = n * n * 32'd15731 + 32'd789221;
        h = n * h + 32'd1376312589;
        h[31] = 1'b0;
        return (longint'(1) << OUT_FRAC_BITS) - longint'(h >> (30 - OUT_FRAC_BITS));
    endfunction

    // Floor each weighted term before the sum.
    function automatic longint lerp_floor(longint p, longint q, longint f);
        return ((p * ((longint'(1) << FRAC_BITS) - f)) >>> FRAC_BITS)
             + ((q * f) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [NOISE_W-1:0] noise_at(logic signed [COORD_W-1:0] x,
                                                           logic signed [COORD_W-1:0] y);
        longint xs;
        longint ys;
        longint xi;
        longint yi;
        longint xf;
        longint yf;
        longint top;
        longint bottom;
        longint r;
        xs = x;
        ys = y;
        xf = xs & ((longint'(1) << FRAC_BITS) - 1);
        yf = ys & ((longint'(1) << FRAC_BITS) - 1);
        // arithmetic shift floors, also for negative points
        xi = xs >>> FRAC_BITS;
        yi = ys >>> FRAC_BITS;
        top    = lerp_floor(corner_level(32'(xi), 32'(yi)),
                            corner_level(32'(xi + 1), 32'(yi)), xf);
        bottom = lerp_floor(corner_level(32'(xi), 32'(yi + 1)),
                            corner_level(32'(xi + 1), 32'(yi + 1)), xf);
        r = lerp_floor(top, bottom, yf);
        return NOISE_W'(r);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        int frac;
        frac = $urandom_range(3);
        case ($urandom_range(3))
            0: return COORD_W'($urandom);
            1: return COORD_W'(int'($urandom_range(4095)) - 2048);
            2: return COORD_W'(((int'($urandom_range(400)) - 200) << FRAC_BITS)
                               | (frac == 0 ? 0 : frac == 1 ? 255 : frac == 2 ? 1 : 128));
            default: return $urandom_range(1) ? COORD_MAX - COORD_W'($urandom_range(1023))
                                              : COORD_MIN + COORD_W'($urandom_range(1023));
        endcase
    endfunction

    task automatic add_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        point_t pt;
        pt.x = x;
        pt.y = y;
        point_backlog.push_back(pt);
    endtask

    // Sender idle and receiver stall odds per phase: swap, then none.
    function automatic int idle_percent(int done, bit receiver);
        int phase;
        phase = done * 3 / points_total;
        if (phase == 0)
            return receiver ? 56 : 38;
        else if (phase == 1)
            return receiver ? 38 : 56;
        return 0;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_points
        point_t pt;
        if (!rst_n)
        begin
            coord_valid <= 1'b0;
            x_coord     <= '0;
            y_coord     <= '0;
        end
        else
        begin
            if (coord_valid && !coord_stall)
            begin
                expected_noise.push_back(noise_at(x_coord, y_coord));
                points_sent++;
            end
            // hold a stalled item; otherwise offer the next one or idle
            if (!coord_valid || !coord_stall)
            begin
                if (point_backlog.size() != 0
                    && $urandom_range(99) >= idle_percent(points_sent, 1'b0))
                begin
                    pt = point_backlog.pop_front();
                    coord_valid <= 1'b1;
                    x_coord     <= pt.x;
                    y_coord     <= pt.y;
                end
                else
                begin
                    coord_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_noise
        logic signed [NOISE_W-1:0] want;
        if (!rst_n)
        begin
            noise_stall <= 1'b0;
        end
        else
        begin
            if (noise_valid && !noise_stall)
            begin
                if (expected_noise.size() == 0)
                begin
                    $error("noise_value: no item expected, actual %0d", noise_value);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_noise.pop_front();
                    if (noise_value !== want)
                    begin
                        $error("noise_value mismatch: expected %0d, actual %0d",
                               want, noise_value);
                        mismatch_count++;
                    end
                end
                noise_seen++;
            end
            noise_stall <= ($urandom_range(99) < idle_percent(noise_seen, 1'b1));
        end
    end

    initial
    begin
        // lattice points, fraction extremes, negative cells and range ends
        add_point(0, 0);
        add_point(1, 1);
        add_point(255, 255);
        add_point(256, 0);
        add_point(0, 256);
        add_point(128, -128);
        add_point(-1, -1);
        add_point(-1, 0);
        add_point(0, -1);
        add_point(-256, -256);
        add_point(-257, -255);
        add_point(-255, 255);
        add_point(COORD_MAX, COORD_MAX);
        add_point(COORD_MIN, COORD_MIN);
        add_point(COORD_MAX, COORD_MIN);
        add_point(COORD_MIN, COORD_MAX);
        add_point(COORD_MIN + 255, COORD_MAX - 255);
        add_point(COORD_MAX - 255, COORD_MIN + 256);
        add_point(24'sh555555, 24'sh2AAAAA);
        add_point(24'sh2AAAAA, 24'sh555555);
        add_point(-24'sd1048576, 24'sd1048831);
        repeat (RANDOM_POINTS)
            add_point(pick_coord(), pick_coord());
        points_total = point_backlog.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (point_backlog.size() != 0 || coord_valid)
            @(posedge clk);
        while (expected_noise.size() != 0)
            @(posedge clk);
        // let any stray item show up
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(20 * 400000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
